### rtl/core/tlvp_pkg.sv
package tlvp_pkg;

  localparam int OFFSET_BITS = 32;
  localparam int CMP_BITS = ((OFFSET_BITS > 32) ? OFFSET_BITS : 32) + 2;

  localparam int HEADER_BYTES = 24;
  localparam int HEAD_BYTES = 6;
  localparam int SIG_BYTES = 4;
  localparam int SIZE_END = 8;
  localparam int TAG_BYTES = 4;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_HEAD   = 2'd1,
    PH_VALUE  = 2'd2,
    PH_IGNORE = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_VALUE  = 2'd1,
    KIND_EMPTY  = 2'd2,
    KIND_END    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SHORT   = 2'd1,
    ST_OVERRUN = 2'd2
  } status_t;

  typedef struct packed {
    logic        has_main;
    kind_t       kind;
    logic [31:0] name_code;
    logic [31:0] data_size;
    logic [7:0]  value_byte;
    logic [15:0] value_index;
    logic [15:0] entry_length;
    logic        has_end;
    status_t     end_status;
  } job_t;

  typedef struct packed {
    logic push;
    logic full;
  } qin_ctl_t;

  typedef struct packed {
    logic pop;
    logic empty;
  } qout_ctl_t;

endpackage

### rtl/core/tlvp_byte_if.sv
interface tlvp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source(output valid, output data_byte, output last_byte, input ready);
  modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

### rtl/core/tlvp_result_if.sv
interface tlvp_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [31:0] name_code;
  logic [31:0] data_size;
  logic [7:0]  value_byte;
  logic [15:0] value_index;
  logic [15:0] entry_length;
  logic [1:0]  end_status;
  logic        last_of_run;

  modport source(
    output valid, output result_kind, output name_code, output data_size,
    output value_byte, output value_index, output entry_length, output end_status,
    output last_of_run, input ready
  );
  modport sink(
    input valid, input result_kind, input name_code, input data_size,
    input value_byte, input value_index, input entry_length, input end_status,
    input last_of_run, output ready
  );
endinterface

### rtl/core/tlvp_front.sv
module tlvp_front (
  input  logic               clk,
  input  logic               rst,
  tlvp_byte_if.sink          bytes,
  output tlvp_pkg::job_t     job,
  output tlvp_pkg::qin_ctl_t qctl_push,
  input  tlvp_pkg::qin_ctl_t qctl_full
);
  import tlvp_pkg::*;

  logic [OFFSET_BITS-1:0] byte_offset, byte_offset_next;
  phase_t                 parse_phase, parse_phase_next;
  logic [31:0]            record_data_size, record_data_size_next;
  logic [31:0]            name_shift, name_shift_next;
  logic [15:0]            length_shift, length_shift_next;
  logic [15:0]            value_count, value_count_next;

  logic [OFFSET_BITS-1:0] pos, nxt;
  logic                   fit;
  phase_t                 phase_after;
  logic [15:0]            len_full;
  logic [16:0]            vc_inc;
  status_t                status;
  logic                   accept;
  logic [7:0]             b;

  assign bytes.ready = !rst && !qctl_full.full;
  assign accept = bytes.valid && bytes.ready;
  assign b = bytes.data_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset      <= '0;
      parse_phase      <= PH_HEADER;
      record_data_size <= '0;
      name_shift       <= '0;
      length_shift     <= '0;
      value_count      <= '0;
    end else if (accept) begin
      byte_offset      <= byte_offset_next;
      parse_phase      <= parse_phase_next;
      record_data_size <= record_data_size_next;
      name_shift       <= name_shift_next;
      length_shift     <= length_shift_next;
      value_count      <= value_count_next;
    end
  end

  always_comb begin
    byte_offset_next      = byte_offset;
    parse_phase_next      = parse_phase;
    record_data_size_next = record_data_size;
    name_shift_next       = name_shift;
    length_shift_next     = length_shift;
    value_count_next      = value_count;
    job                   = '0;
    status                = ST_OK;
    len_full              = {b, length_shift[7:0]};
    vc_inc                = {1'b0, value_count} + 17'd1;

    pos = byte_offset;
    nxt = (pos == {OFFSET_BITS{1'b1}}) ? pos : pos + 1'b1;
    fit = (CMP_BITS'(nxt) + CMP_BITS'(HEAD_BYTES))
          <= (CMP_BITS'(HEADER_BYTES) + CMP_BITS'(record_data_size));
    phase_after = fit ? PH_HEAD : PH_IGNORE;

    unique case (parse_phase)
      PH_HEADER: begin
        if (pos < OFFSET_BITS'(SIG_BYTES)) begin
          name_shift_next = {b, name_shift[31:8]};
        end else if (pos < OFFSET_BITS'(SIZE_END)) begin
          record_data_size_next = {b, record_data_size[31:8]};
        end
        if (pos == OFFSET_BITS'(HEADER_BYTES - 1)) begin
          job.has_main     = 1'b1;
          job.kind         = KIND_HEADER;
          job.name_code    = name_shift;
          job.data_size    = record_data_size;
          name_shift_next  = '0;
          value_count_next = '0;
          parse_phase_next = phase_after;
        end else if (bytes.last_byte) begin
          status = ST_SHORT;
        end
      end
      PH_HEAD: begin
        if (value_count < 16'(TAG_BYTES)) begin
          name_shift_next  = {b, name_shift[31:8]};
          value_count_next = vc_inc[15:0];
        end else if (value_count == 16'(TAG_BYTES)) begin
          length_shift_next = {8'd0, b};
          value_count_next  = vc_inc[15:0];
        end else begin
          length_shift_next = len_full;
          value_count_next  = '0;
          if (len_full == 16'd0) begin
            job.has_main     = 1'b1;
            job.kind         = KIND_EMPTY;
            job.name_code    = name_shift;
            name_shift_next  = '0;
            parse_phase_next = phase_after;
          end else begin
            parse_phase_next = PH_VALUE;
            if (bytes.last_byte) status = ST_OVERRUN;
          end
        end
      end
      PH_VALUE: begin
        job.has_main     = 1'b1;
        job.kind         = KIND_VALUE;
        job.name_code    = name_shift;
        job.value_byte   = b;
        job.value_index  = value_count;
        job.entry_length = length_shift;
        if (vc_inc >= {1'b0, length_shift}) begin
          value_count_next  = '0;
          name_shift_next   = '0;
          length_shift_next = '0;
          parse_phase_next  = phase_after;
        end else begin
          value_count_next = vc_inc[15:0];
          if (bytes.last_byte) status = ST_OVERRUN;
        end
      end
      PH_IGNORE: begin
      end
    endcase

    byte_offset_next = nxt;

    if (bytes.last_byte) begin
      job.has_end           = 1'b1;
      job.end_status        = status;
      byte_offset_next      = '0;
      parse_phase_next      = PH_HEADER;
      record_data_size_next = '0;
      name_shift_next       = '0;
      length_shift_next     = '0;
      value_count_next      = '0;
    end

    qctl_push.push = accept && (job.has_main || job.has_end);
    qctl_push.full = 1'b0;
  end

  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    accept && bytes.last_byte |=> byte_offset == '0 && parse_phase == PH_HEADER)
    else $error("record state not cleared after last beat");

  a_value_count: assert property (@(posedge clk) disable iff (rst)
    parse_phase == PH_VALUE |-> value_count < length_shift)
    else $error("value position reached entry length");

endmodule

### rtl/core/tlvp_queue.sv
module tlvp_queue (
  input  logic                clk,
  input  logic                rst,
  input  tlvp_pkg::job_t      wr_job,
  input  tlvp_pkg::qin_ctl_t  wr_ctl,
  output tlvp_pkg::qin_ctl_t  wr_stat,
  output tlvp_pkg::job_t      rd_job,
  input  tlvp_pkg::qout_ctl_t rd_ctl,
  output tlvp_pkg::qout_ctl_t rd_stat
);
  import tlvp_pkg::*;

  job_t                 slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;
  logic                 do_push, do_pop;

  assign wr_stat.push  = 1'b0;
  assign wr_stat.full  = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign rd_stat.pop   = 1'b0;
  assign rd_stat.empty = (count == '0);
  assign rd_job        = slots[rd_ptr];

  assign do_push = wr_ctl.push && !wr_stat.full;
  assign do_pop  = rd_ctl.pop && !rd_stat.empty;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    wr_ctl.push |-> !wr_stat.full)
    else $error("push into full queue");

endmodule

### rtl/core/tlvp_back.sv
module tlvp_back (
  input  logic                clk,
  input  logic                rst,
  input  tlvp_pkg::job_t      head,
  input  tlvp_pkg::qout_ctl_t q_stat,
  output tlvp_pkg::qout_ctl_t q_ctl,
  tlvp_result_if.source       results
);
  import tlvp_pkg::*;

  logic        out_valid;
  logic        half, half_next;
  logic        load, sel_end;
  kind_t       kind_next;
  logic [31:0] name_next, size_next;
  logic [7:0]  vbyte_next;
  logic [15:0] vidx_next, elen_next;
  status_t     status_next;
  logic        last_next;

  assign results.valid = out_valid;
  assign load = !out_valid || results.ready;
  assign sel_end = half || !head.has_main;

  always_comb begin
    q_ctl.empty = 1'b0;
    q_ctl.pop   = 1'b0;
    half_next   = half;
    kind_next   = KIND_END;
    name_next   = '0;
    size_next   = '0;
    vbyte_next  = '0;
    vidx_next   = '0;
    elen_next   = '0;
    status_next = ST_OK;
    last_next   = 1'b1;
    if (sel_end) begin
      status_next = head.end_status;
    end else begin
      kind_next  = head.kind;
      name_next  = head.name_code;
      size_next  = head.data_size;
      vbyte_next = head.value_byte;
      vidx_next  = head.value_index;
      elen_next  = head.entry_length;
      last_next  = !head.has_end;
    end
    if (load && !q_stat.empty) begin
      if (sel_end) begin
        q_ctl.pop = 1'b1;
        half_next = 1'b0;
      end else if (head.has_end) begin
        half_next = 1'b1;
      end else begin
        q_ctl.pop = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      half      <= 1'b0;
    end else begin
      half <= half_next;
      if (load) out_valid <= !q_stat.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_stat.empty) begin
      results.result_kind  <= kind_next;
      results.name_code    <= name_next;
      results.data_size    <= size_next;
      results.value_byte   <= vbyte_next;
      results.value_index  <= vidx_next;
      results.entry_length <= elen_next;
      results.end_status   <= status_next;
      results.last_of_run  <= last_next;
    end
  end

  a_half_has_head: assert property (@(posedge clk) disable iff (rst)
    half |-> !q_stat.empty)
    else $error("end beat pending with empty queue");

endmodule

### rtl/core/tlv_record_stream_parser.sv
// Parses a TLV record arriving one byte per beat, with last_byte on the final byte: a
// 24-byte header (signature, little-endian 32-bit data size), then entries of a 4-byte
// tag, a 16-bit little-endian length and the value bytes. It takes one byte per clock
// while its four-entry queue is not full; the parser updates its state per byte and
// writes what the byte yields into that queue, and the output stage drains the queue one
// result per cycle while the consumer is ready, through a registered output. A byte gives
// at most two results (a header, value or empty-entry result plus the end result on the
// last byte); the queue absorbs the extra end result. A result passes from the queue slot
// to the output register. Value bytes are sent as they arrive: on an overrun end status
// the consumer drops the last entry.
module tlv_record_stream_parser (
  input logic           clk,
  input logic           rst,
  tlvp_byte_if.sink     bytes,
  tlvp_result_if.source results
);
  import tlvp_pkg::*;

  job_t      push_job, head_job;
  qin_ctl_t  push_ctl, push_stat;
  qout_ctl_t pop_ctl, pop_stat;

  tlvp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .bytes     (bytes),
    .job       (push_job),
    .qctl_push (push_ctl),
    .qctl_full (push_stat)
  );

  tlvp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_job  (push_job),
    .wr_ctl  (push_ctl),
    .wr_stat (push_stat),
    .rd_job  (head_job),
    .rd_ctl  (pop_ctl),
    .rd_stat (pop_stat)
  );

  tlvp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head_job),
    .q_stat  (pop_stat),
    .q_ctl   (pop_ctl),
    .results (results)
  );

endmodule
